// ===== sv/qrs_pkg.sv =====
// shared constants for the quadratic root solver
// no dependencies
package qrs_pkg;

  // default word format, signed Q16.16
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 8;

  // root kind codes
  localparam logic [1:0] KIND_TWO   = 2'd0;
  localparam logic [1:0] KIND_ONE   = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;
  localparam logic [1:0] KIND_DEGEN = 2'd3;

endpackage

// ===== sv/qrs_in_if.sv =====
// input channel of the root solver: coefficient word with valid/ready
// no dependencies
interface qrs_in_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_a;
  logic signed [W-1:0] coef_b;
  logic signed [W-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// ===== sv/qrs_out_if.sv =====
// output channel of the root solver: root word with valid/ready
// no dependencies
interface qrs_out_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] root_plus;
  logic signed [W-1:0] root_minus;
  logic [1:0]          root_kind;
  logic                overflow;

  modport source (output valid, root_plus, root_minus, root_kind, overflow, input ready);
  modport sink (input valid, root_plus, root_minus, root_kind, overflow, output ready);
endinterface

// ===== sv/qrs_front.sv =====
// front end: accepts coefficient words, forms the discriminant and classifies
// depends on qrs_pkg and qrs_in_if
module qrs_front #(
  parameter int W     = 32,
  parameter int DEPTH = 8,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  qrs_in_if.sink            in_ch,
  input  logic [CW-1:0]     q_count,
  output logic              push,
  output logic              aneg,
  output logic [W-1:0]      amag,
  output logic              bneg,
  output logic [W-1:0]      bmag,
  output logic [2*W+1:0]    disc,
  output logic [1:0]        kind
);
  import qrs_pkg::*;

  localparam int DW = 2 * W + 2;
  localparam int UW = CW + 1;

  logic           v0, v1;
  logic           a0n, b0n, c0n;
  logic [W-1:0]   a0m, b0m, c0m;
  logic           a1n, b1n, a1z, c1z, sd1;
  logic [W-1:0]   a1m, b1m;
  logic [2*W-1:0] bb1, ac1;
  logic [UW-1:0]  used;
  logic [DW-1:0]  bbx, ac4;

  // credit: queue entries plus words still in the front
  assign used = UW'(q_count) + UW'(v0) + UW'(v1) + UW'(push);
  assign in_ch.ready = used < UW'(DEPTH);

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      push <= 1'b0;
    end else begin
      v0   <= in_ch.valid && in_ch.ready;
      v1   <= v0;
      push <= v1;
    end
  end

  // sign and magnitude split
  always_ff @(posedge clk) begin
    a0n <= in_ch.coef_a[W-1];
    b0n <= in_ch.coef_b[W-1];
    c0n <= in_ch.coef_c[W-1];
    a0m <= in_ch.coef_a[W-1] ? W'(-in_ch.coef_a) : W'(in_ch.coef_a);
    b0m <= in_ch.coef_b[W-1] ? W'(-in_ch.coef_b) : W'(in_ch.coef_b);
    c0m <= in_ch.coef_c[W-1] ? W'(-in_ch.coef_c) : W'(in_ch.coef_c);
  end

  // products b*b and a*c
  always_ff @(posedge clk) begin
    bb1 <= b0m * b0m;
    ac1 <= a0m * c0m;
    a1n <= a0n;
    b1n <= b0n;
    a1m <= a0m;
    b1m <= b0m;
    a1z <= (a0m == '0);
    c1z <= (c0m == '0);
    sd1 <= a0n ^ c0n;
  end

  // discriminant and kind
  assign bbx = DW'(bb1);
  assign ac4 = {ac1, 2'b00};

  always_ff @(posedge clk) begin
    aneg <= a1n;
    amag <= a1m;
    bneg <= b1n;
    bmag <= b1m;
    if (a1z) begin
      disc <= '0;
      kind <= KIND_DEGEN;
    end else if (!c1z && sd1) begin
      disc <= bbx + ac4;
      kind <= KIND_TWO;
    end else if (bbx > ac4) begin
      disc <= bbx - ac4;
      kind <= KIND_TWO;
    end else if (bbx == ac4) begin
      disc <= '0;
      kind <= KIND_ONE;
    end else begin
      disc <= '0;
      kind <= KIND_NONE;
    end
  end
endmodule

// ===== sv/qrs_queue.sv =====
// short word queue between front and back
// depends on qrs_pkg
module qrs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             avail,
  output logic [CW-1:0]    count
);
  import qrs_pkg::*;

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;

  assign head  = store[rd_ptr];
  assign avail = (count != '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end
endmodule

// ===== sv/qrs_back.sv =====
// back end: pipelined square root, two pipelined dividers, saturation
// depends on qrs_pkg and qrs_out_if
module qrs_back #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  logic           aneg,
  input  logic [W-1:0]   amag,
  input  logic           bneg,
  input  logic [W-1:0]   bmag,
  input  logic [2*W+1:0] disc,
  input  logic [1:0]     kind,
  output logic           pop,
  qrs_out_if.source      out_ch
);
  import qrs_pkg::*;

  localparam int SW  = W + 1;         // root bits
  localparam int DW  = 2 * SW;        // discriminant bits
  localparam int RW  = SW + 3;        // partial remainder of the root
  localparam int SDW = 2 * W + 4;     // side word through the root stages
  localparam int NW  = W + 3;         // signed numerator
  localparam int XW  = W + F + 2;     // dividend and quotient bits

  logic adv;

  // whole back end moves when the output register can take a word
  assign adv = !out_ch.valid || out_ch.ready;
  assign pop = adv && avail;

  // ---------------- square root stages ----------------
  logic           sv   [SW+1];
  logic [RW-1:0]  srem [SW+1];
  logic [SW-1:0]  sroot[SW+1];
  logic [DW-1:0]  sd   [SW+1];
  logic [SDW-1:0] sside[SW+1];

  // load from the queue head
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      srem[0]  <= '0;
      sroot[0] <= '0;
      sd[0]    <= disc;
      sside[0] <= {aneg, amag, bneg, bmag, kind};
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [RW-1:0] rem_sh, trial, diff;
    logic          ge;

    assign rem_sh = {srem[k][RW-3:0], sd[k][DW-1:DW-2]};
    assign trial  = {1'b0, sroot[k], 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        srem[k+1]  <= ge ? diff : rem_sh;
        sroot[k+1] <= {sroot[k][SW-2:0], ge};
        sd[k+1]    <= {sd[k][DW-3:0], 2'b00};
        sside[k+1] <= sside[k];
      end
    end
  end

  // ---------------- numerators -b +/- s ----------------
  logic                 s_aneg, s_bneg;
  logic [W-1:0]         s_amag, s_bmag;
  logic [1:0]           s_kind;
  logic signed [NW-1:0] negb, sroot_x;

  assign {s_aneg, s_amag, s_bneg, s_bmag, s_kind} = sside[SW];
  assign negb    = s_bneg ? $signed(NW'(s_bmag)) : -$signed(NW'(s_bmag));
  assign sroot_x = $signed(NW'(sroot[SW]));

  logic                 nv;
  logic signed [NW-1:0] num_p, num_m;
  logic                 n_aneg;
  logic [W-1:0]         n_amag;
  logic [1:0]           n_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      nv <= 1'b0;
    end else if (adv) begin
      nv <= sv[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_p  <= negb + sroot_x;
      num_m  <= negb - sroot_x;
      n_aneg <= s_aneg;
      n_amag <= s_amag;
      n_kind <= s_kind;
    end
  end

  // ---------------- divider stages, two lanes ----------------
  logic          dvv  [XW+1];
  logic [W:0]    rp   [XW+1];
  logic [W:0]    rm   [XW+1];
  logic [XW-1:0] qp   [XW+1];
  logic [XW-1:0] qm   [XW+1];
  logic [W:0]    dvs  [XW+1];
  logic          negp [XW+1];
  logic          negm [XW+1];
  logic [1:0]    dkind[XW+1];

  logic [NW-1:0] mag_p, mag_m;

  assign mag_p = num_p[NW-1] ? NW'(-num_p) : NW'(num_p);
  assign mag_m = num_m[NW-1] ? NW'(-num_m) : NW'(num_m);

  // magnitudes and result signs
  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rp[0]    <= '0;
      rm[0]    <= '0;
      qp[0]    <= XW'(mag_p[NW-2:0]) << F;
      qm[0]    <= XW'(mag_m[NW-2:0]) << F;
      dvs[0]   <= {n_amag, 1'b0};
      negp[0]  <= num_p[NW-1] ^ n_aneg;
      negm[0]  <= num_m[NW-1] ^ n_aneg;
      dkind[0] <= n_kind;
    end
  end

  // one quotient bit per stage and lane
  for (genvar k = 0; k < XW; k++) begin : g_div
    logic [W+1:0] r2p, r2m, dvx, dfp, dfm;
    logic         gep, gem;

    assign dvx = {1'b0, dvs[k]};
    assign r2p = {rp[k], qp[k][XW-1]};
    assign r2m = {rm[k], qm[k][XW-1]};
    assign gep = r2p >= dvx;
    assign gem = r2m >= dvx;
    assign dfp = r2p - dvx;
    assign dfm = r2m - dvx;

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (adv) begin
        dvv[k+1] <= dvv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rp[k+1]    <= gep ? dfp[W:0] : r2p[W:0];
        rm[k+1]    <= gem ? dfm[W:0] : r2m[W:0];
        qp[k+1]    <= {qp[k][XW-2:0], gep};
        qm[k+1]    <= {qm[k][XW-2:0], gem};
        dvs[k+1]   <= dvs[k];
        negp[k+1]  <= negp[k];
        negm[k+1]  <= negm[k];
        dkind[k+1] <= dkind[k];
      end
    end
  end

  // ---------------- saturation and output register ----------------
  logic [XW-1:0] lim_p, lim_m;
  logic          ovf_p, ovf_m;
  logic [W-1:0]  sat_p, sat_m;
  logic [W-1:0]  res_p, res_m;

  assign lim_p = negp[XW] ? (XW'(1) << (W - 1)) : (XW'(1) << (W - 1)) - XW'(1);
  assign lim_m = negm[XW] ? (XW'(1) << (W - 1)) : (XW'(1) << (W - 1)) - XW'(1);
  assign ovf_p = qp[XW] > lim_p;
  assign ovf_m = qm[XW] > lim_m;
  assign sat_p = ovf_p ? lim_p[W-1:0] : qp[XW][W-1:0];
  assign sat_m = ovf_m ? lim_m[W-1:0] : qm[XW][W-1:0];
  assign res_p = negp[XW] ? W'(-sat_p) : sat_p;
  assign res_m = negm[XW] ? W'(-sat_m) : sat_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= dvv[XW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.root_kind <= dkind[XW];
      case (dkind[XW])
        KIND_TWO, KIND_ONE: begin
          out_ch.root_plus  <= $signed(res_p);
          out_ch.root_minus <= $signed(res_m);
          out_ch.overflow   <= ovf_p | ovf_m;
        end
        default: begin
          out_ch.root_plus  <= '0;
          out_ch.root_minus <= '0;
          out_ch.overflow   <= 1'b0;
        end
      endcase
    end
  end
endmodule

// ===== sv/quadratic_root_solver_core.sv =====
// throughput: one word per cycle; the root takes WORD_BITS+1 stages, each divider
// WORD_BITS+FRAC_BITS+2 stages, a stalled output freezes the back end
// reset: synchronous, clears valid bits and the queue; no clearing pass
// depends on qrs_pkg, qrs_in_if, qrs_out_if, qrs_front, qrs_queue, qrs_back
module quadratic_root_solver_core #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  qrs_in_if.sink    in_ch,
  qrs_out_if.source out_ch
);
  import qrs_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int DW = 2 * W + 2;
  localparam int QW = 1 + W + 1 + W + DW + 2;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          push, pop, avail;
  logic [CW-1:0] q_count;
  logic          f_aneg, f_bneg, h_aneg, h_bneg;
  logic [W-1:0]  f_amag, f_bmag, h_amag, h_bmag;
  logic [DW-1:0] f_disc, h_disc;
  logic [1:0]    f_kind, h_kind;
  logic [QW-1:0] head;

  // classify and form the discriminant
  qrs_front #(.W(W), .DEPTH(QUEUE_DEPTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_count (q_count),
    .push    (push),
    .aneg    (f_aneg),
    .amag    (f_amag),
    .bneg    (f_bneg),
    .bmag    (f_bmag),
    .disc    (f_disc),
    .kind    (f_kind)
  );

  // decoupling queue
  qrs_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_aneg, f_amag, f_bneg, f_bmag, f_disc, f_kind}),
    .pop       (pop),
    .head      (head),
    .avail     (avail),
    .count     (q_count)
  );

  assign {h_aneg, h_amag, h_bneg, h_bmag, h_disc, h_kind} = head;

  // root and division pipeline
  qrs_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk    (clk),
    .rst    (rst),
    .avail  (avail),
    .aneg   (h_aneg),
    .amag   (h_amag),
    .bneg   (h_bneg),
    .bmag   (h_bmag),
    .disc   (h_disc),
    .kind   (h_kind),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // queue never written when full
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_count != CW'(QUEUE_DEPTH)))
    else $error("queue overrun");

  // no roots for zero a or negative discriminant
  a_empty_kinds: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.root_kind == KIND_DEGEN || out_ch.root_kind == KIND_NONE)
    |-> (out_ch.root_plus == '0) && (out_ch.root_minus == '0) && !out_ch.overflow)
    else $error("nonzero roots without real solution");

  // double root gives equal roots
  a_double: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.root_kind == KIND_ONE)
    |-> (out_ch.root_plus == out_ch.root_minus))
    else $error("double root differs");
endmodule
